// ----- design/spl_pkg.sv -----
`default_nettype none

package spl_pkg;

  localparam int DEPTH      = 64;
  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_PRUNE  = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_READ   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_PRUNE_INIT,
    S_PRUNE_STEP,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } point_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [FIELD_W-1:0] point_x;
    logic [FIELD_W-1:0] point_y;
    logic [FIELD_W-1:0] point_z;
    logic [5:0]         position;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         count;
    logic [FIELD_W-1:0] front_x;
    logic [FIELD_W-1:0] front_y;
    logic [FIELD_W-1:0] front_z;
    logic [FIELD_W-1:0] last_x;
    logic [FIELD_W-1:0] last_y;
    logic [FIELD_W-1:0] last_z;
    logic [FIELD_W-1:0] read_x;
    logic [FIELD_W-1:0] read_y;
    logic [FIELD_W-1:0] read_z;
  } out_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [CNT_W-1:0] rem_pos;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] sel_a;
    logic [CNT_W-1:0] sel_b;
    point_t           point;
  } cell_ctrl_t;

  // Order is (x, z, y); true when a is smaller than b.
  function automatic logic pt_less(point_t a, point_t b);
    logic r;
    if (a.x != b.x) begin
      r = a.x < b.x;
    end else if (a.z != b.z) begin
      r = a.z < b.z;
    end else begin
      r = a.y < b.y;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/sorted_point_priority_list.sv -----
`default_nettype none

// Sorted list of up to DEPTH points kept in descending (x, z, y) order, one
// point per cell of a shifting row. Each transfer starts on start while busy is
// low and produces exactly one result, shown for one cycle with out_strobe;
// busy falls in that same cycle, so the next item may start right away. Push,
// pop, remove, clear and read go through a compare pass over the row (S_CMP),
// an apply step in which the moving cells all shift at once (S_APPLY) and a
// report step that picks the back and read points out of the row (S_REPORT).
// Prune walks the list from the back one neighbor pair per cycle after the
// compare pass, or skips the walk when fewer than two points are stored. The
// result cannot be held off by the receiver.
module sorted_point_priority_list import spl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_strobe,
  output out_t      out_data
);

  state_t           state_r, state_nxt;
  in_t              cmd_r, cmd_nxt;
  logic             dup_r, dup_nxt;
  status_t          status_r, status_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  point_t           q_r, q_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_t             out_r, out_nxt;

  cell_ctrl_t       ctrl;
  point_t           cmd_point;
  logic             pos_ok;
  logic             eq_any;
  point_t           a_any;
  point_t           b_any;
  logic             prune_hit;

  point_t           entry_w [DEPTH];
  point_t           a_w     [DEPTH];
  point_t           b_w     [DEPTH];
  logic             lt_w    [DEPTH];
  logic             eq_w    [DEPTH];

  assign cmd_point.x = COORD_BITS'(cmd_r.point_x);
  assign cmd_point.y = COORD_BITS'(cmd_r.point_y);
  assign cmd_point.z = COORD_BITS'(cmd_r.point_z);
  assign pos_ok      = 32'(cmd_r.position) < 32'(count_r);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    point_t left_w;
    point_t right_w;
    logic   lt_left_w;
    if (g == 0) begin : g_first
      assign left_w    = '0;
      assign lt_left_w = 1'b1;
    end else begin : g_mid
      assign left_w    = entry_w[g-1];
      assign lt_left_w = lt_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = entry_w[g+1];
    end
    spl_cell u_cell (
      .clk       (clk),
      .idx_i     (CNT_W'(g)),
      .ctrl_i    (ctrl),
      .left_i    (left_w),
      .lt_left_i (lt_left_w),
      .right_i   (right_w),
      .entry_o   (entry_w[g]),
      .lt_o      (lt_w[g]),
      .eq_o      (eq_w[g]),
      .a_o       (a_w[g]),
      .b_o       (b_w[g])
    );
  end

  // Only one cell can match each select, so an OR gathers the picked entry.
  always_comb begin
    eq_any = 1'b0;
    a_any  = '0;
    b_any  = '0;
    for (int k = 0; k < DEPTH; k++) begin
      eq_any = eq_any | eq_w[k];
      a_any  = a_any | a_w[k];
      b_any  = b_any | b_w[k];
    end
  end

  // The earlier entry of the pair goes when it shares x and z with the later
  // survivor, or has a smaller x with the same y and z.
  assign prune_hit = ((a_any.x == q_r.x) && (a_any.z == q_r.z)) ||
                     ((a_any.x < q_r.x) && (a_any.y == q_r.y) && (a_any.z == q_r.z));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    dup_r    <= dup_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    q_r      <= q_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    dup_nxt        = dup_r;
    status_nxt     = status_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    q_nxt          = q_r;
    out_nxt        = out_r;
    out_strobe_nxt = 1'b0;

    ctrl.ins     = 1'b0;
    ctrl.rem     = 1'b0;
    ctrl.rem_pos = '0;
    ctrl.count   = count_r;
    ctrl.sel_a   = '0;
    ctrl.sel_b   = '0;
    ctrl.point   = cmd_point;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_data;
          status_nxt = ST_OK;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        dup_nxt = eq_any;
        if (op_t'(cmd_r.operation) == OP_PRUNE) begin
          state_nxt = S_PRUNE_INIT;
        end else begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        state_nxt = S_REPORT;
        unique case (op_t'(cmd_r.operation))
          OP_PUSH: begin
            if (dup_r) begin
              status_nxt = ST_DUP;
            end else if (count_r == CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ctrl.ins  = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          OP_POP: begin
            if (count_r != '0) begin
              ctrl.rem  = 1'b1;
              count_nxt = count_r - 1'b1;
            end
          end
          OP_REMOVE: begin
            if (pos_ok) begin
              ctrl.rem     = 1'b1;
              ctrl.rem_pos = CNT_W'(cmd_r.position);
              count_nxt    = count_r - 1'b1;
            end else begin
              status_nxt = ST_RANGE;
            end
          end
          OP_CLEAR: begin
            count_nxt = '0;
          end
          OP_READ: begin
            if (!pos_ok) begin
              status_nxt = ST_RANGE;
            end
          end
          default: begin
          end
        endcase
      end
      S_PRUNE_INIT: begin
        ctrl.sel_b = count_r - 1'b1;
        q_nxt      = b_any;
        idx_nxt    = count_r - 1'b1;
        if (count_r >= CNT_W'(2)) begin
          state_nxt = S_PRUNE_STEP;
        end else begin
          state_nxt = S_REPORT;
        end
      end
      S_PRUNE_STEP: begin
        if (idx_r == '0) begin
          state_nxt = S_REPORT;
        end else begin
          ctrl.sel_a = idx_r - 1'b1;
          if (prune_hit) begin
            ctrl.rem     = 1'b1;
            ctrl.rem_pos = idx_r - 1'b1;
            count_nxt    = count_r - 1'b1;
          end else begin
            q_nxt = a_any;
          end
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_REPORT: begin
        ctrl.sel_a = CNT_W'(cmd_r.position);
        ctrl.sel_b = count_r - 1'b1;
        out_nxt.status  = status_r;
        out_nxt.count   = 7'(count_r);
        out_nxt.front_x = '0;
        out_nxt.front_y = '0;
        out_nxt.front_z = '0;
        if (count_r != '0) begin
          out_nxt.front_x = FIELD_W'(entry_w[0].x);
          out_nxt.front_y = FIELD_W'(entry_w[0].y);
          out_nxt.front_z = FIELD_W'(entry_w[0].z);
        end
        out_nxt.last_x = FIELD_W'(b_any.x);
        out_nxt.last_y = FIELD_W'(b_any.y);
        out_nxt.last_z = FIELD_W'(b_any.z);
        out_nxt.read_x = '0;
        out_nxt.read_y = '0;
        out_nxt.read_z = '0;
        if (op_t'(cmd_r.operation) == OP_READ && pos_ok) begin
          out_nxt.read_x = FIELD_W'(a_any.x);
          out_nxt.read_y = FIELD_W'(a_any.y);
          out_nxt.read_z = FIELD_W'(a_any.z);
        end
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

`default_nettype wire

// ----- design/spl_cell.sv -----
`default_nettype none

module spl_cell import spl_pkg::*; (
  input  wire logic             clk,
  input  wire logic [CNT_W-1:0] idx_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire point_t           left_i,
  input  wire logic             lt_left_i,
  input  wire point_t           right_i,
  output point_t                entry_o,
  output logic                  lt_o,
  output logic                  eq_o,
  output point_t                a_o,
  output point_t                b_o
);

  point_t entry_r;
  point_t entry_nxt;
  logic   occ;

  assign occ     = idx_i < ctrl_i.count;
  assign entry_o = entry_r;
  assign lt_o    = occ && pt_less(ctrl_i.point, entry_r);
  assign eq_o    = occ && (entry_r == ctrl_i.point);
  assign a_o     = (occ && idx_i == ctrl_i.sel_a) ? entry_r : '0;
  assign b_o     = (occ && idx_i == ctrl_i.sel_b) ? entry_r : '0;

  // On insert the cell where the new point belongs takes it and every cell
  // behind it takes its left neighbor; on removal the tail moves up by one.
  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl_i.ins) begin
      if (lt_o) begin
        entry_nxt = entry_r;
      end else if (lt_left_i) begin
        entry_nxt = ctrl_i.point;
      end else begin
        entry_nxt = left_i;
      end
    end else if (ctrl_i.rem && idx_i >= ctrl_i.rem_pos) begin
      entry_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ----- design/spl_checker.sv -----
`default_nettype none

module spl_checker import spl_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_strobe,
  input wire out_t out_data
);

  // Every finished item ends its busy period with exactly one result.
  a_busy_end_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy fell without a result");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not make the block busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while still busy");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.count == '0) |->
      (out_data.front_x == '0 && out_data.front_y == '0 && out_data.front_z == '0 &&
       out_data.last_x == '0 && out_data.last_y == '0 && out_data.last_z == '0))
    else $error("empty list reports a nonzero front or back point");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == ST_FULL) |-> (out_data.count == 7'(DEPTH)))
    else $error("full status reported with a list that is not full");

endmodule

bind sorted_point_priority_list spl_checker u_spl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

`default_nettype wire
